>>> hw/rtl/cbwc_pkg.sv
// shared constants, codes and the chain token type for the clock bitmap window counter
package cbwc_pkg;

  localparam int CELLS     = 4096;
  localparam int LANES     = 16;
  localparam int ROWS      = CELLS / LANES;
  localparam int IDX_W     = $clog2(CELLS);
  localparam int LANE_W    = $clog2(LANES);
  localparam int ROW_W     = $clog2(ROWS);
  localparam int CLK_W     = 16;
  localparam int AMT_W     = 24;
  localparam int BASE_W    = AMT_W - IDX_W;
  localparam int DEC_W     = BASE_W + 1;
  localparam int CNT_W     = 13;
  localparam int ZS_W      = $clog2(LANES + 1);
  localparam int FUNC_W    = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SWEEP  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_CLOCK    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_AMOUNT = 1'd1;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_SWEEP  = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  // one row command travelling down the cell chain
  typedef struct packed {
    logic              vld;
    op_t               op;
    logic              last;
    logic [ROW_W-1:0]  row;
    logic [LANE_W-1:0] lane_sel;
    logic [CLK_W-1:0]  wdata;
    logic [BASE_W-1:0] base;
    logic [IDX_W-1:0]  extra;
    logic [IDX_W-1:0]  ptr;
    logic [ZS_W-1:0]   zsum;
  } tok_t;

endpackage

>>> hw/rtl/cbwc_cell.sv
// one lane of the chain: a row memory of clock counters with read-modify-write
module cbwc_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [cbwc_pkg::LANE_W-1:0] lane,
  input  cbwc_pkg::tok_t            tok_in,
  output cbwc_pkg::tok_t            tok_out
);
  import cbwc_pkg::*;

  logic [CLK_W-1:0] mem [ROWS];
  logic [CLK_W-1:0] rdata;
  tok_t             s1;
  tok_t             tok_mod;
  logic             fw_vld;
  logic [CLK_W-1:0] fw_data;
  logic [CLK_W-1:0] cur;
  logic [CLK_W-1:0] new_val;
  logic [CLK_W-1:0] swept;
  logic [CLK_W-1:0] dec_ext;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] off;
  logic [DEC_W-1:0] dec;
  logic             wen;

  always_ff @(posedge clk) begin
    rdata <= mem[tok_in.row];
    if (wen) begin
      mem[s1.row] <= new_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.vld      <= 1'b0;
      tok_out.vld <= 1'b0;
      fw_vld      <= 1'b0;
    end else begin
      s1      <= tok_in;
      tok_out <= tok_mod;
      // back-to-back access to the same row reads the value just written
      fw_vld  <= wen && (s1.row == tok_in.row);
    end
    fw_data <= new_val;
  end

  always_comb begin
    cur     = fw_vld ? fw_data : rdata;
    idx     = {s1.row, lane};
    off     = idx - s1.ptr;
    dec     = DEC_W'(s1.base) + DEC_W'(off < s1.extra);
    dec_ext = CLK_W'(dec);
    swept   = (cur <= dec_ext) ? '0 : cur - dec_ext;

    wen     = 1'b0;
    new_val = '0;
    case (s1.op)
      OP_CLEAR: begin
        wen     = s1.vld;
        new_val = '0;
      end
      OP_INSERT: begin
        wen     = s1.vld && (lane == s1.lane_sel);
        new_val = s1.wdata;
      end
      OP_SWEEP: begin
        wen     = s1.vld;
        new_val = swept;
      end
      OP_QUERY: begin
        wen     = 1'b0;
        new_val = cur;
      end
      default: begin
        wen     = 1'b0;
        new_val = cur;
      end
    endcase

    tok_mod = s1;
    if (s1.op == OP_QUERY && cur == '0) begin
      tok_mod.zsum = s1.zsum + ZS_W'(1);
    end
  end

endmodule

>>> hw/rtl/cbwc_ctrl.sv
// command sequencer: config registers, sweep pointer and row token issue
module cbwc_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [cbwc_pkg::FUNC_W-1:0]  func,
  input  logic [cbwc_pkg::IDX_W-1:0]   cell_index,
  input  logic                         cfg_we,
  input  logic [cbwc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cbwc_pkg::AMT_W-1:0]   cfg_data,
  input  logic                         result_taken,
  output cbwc_pkg::tok_t               tok
);
  import cbwc_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_RUN   = 4'b0100,
    S_WAIT  = 4'b1000
  } state_t;

  state_t           state, state_next;
  logic [ROW_W-1:0] row_cnt, row_cnt_next;
  logic [CLK_W-1:0] max_clock;
  logic [AMT_W-1:0] sweep_amount;
  logic [IDX_W-1:0] sweep_pointer, sweep_pointer_next;
  tok_t             tok_next;
  logic             last_row;

  assign in_stall = (state != S_IDLE);
  assign last_row = (row_cnt == ROW_W'(ROWS - 1));

  always_comb begin
    state_next         = state;
    row_cnt_next       = row_cnt;
    sweep_pointer_next = sweep_pointer;
    tok_next           = tok;
    tok_next.vld       = 1'b0;
    tok_next.last      = 1'b0;
    tok_next.zsum      = '0;
    case (state)
      S_CLEAR: begin
        tok_next.vld  = 1'b1;
        tok_next.op   = OP_CLEAR;
        tok_next.row  = row_cnt;
        tok_next.last = last_row;
        row_cnt_next  = row_cnt + ROW_W'(1);
        if (last_row) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          case (func)
            FUNC_INSERT: begin
              tok_next.vld      = 1'b1;
              tok_next.op       = OP_INSERT;
              tok_next.row      = cell_index[IDX_W-1:LANE_W];
              tok_next.lane_sel = cell_index[LANE_W-1:0];
              tok_next.wdata    = max_clock;
            end
            FUNC_SWEEP: begin
              tok_next.op        = OP_SWEEP;
              tok_next.base      = sweep_amount[AMT_W-1:IDX_W];
              tok_next.extra     = sweep_amount[IDX_W-1:0];
              tok_next.ptr       = sweep_pointer;
              sweep_pointer_next = sweep_pointer + sweep_amount[IDX_W-1:0];
              row_cnt_next       = '0;
              state_next         = S_RUN;
            end
            FUNC_QUERY: begin
              tok_next.op  = OP_QUERY;
              row_cnt_next = '0;
              state_next   = S_RUN;
            end
            default: begin
              // unused code, nothing to do
            end
          endcase
        end
      end
      S_RUN: begin
        tok_next.vld  = 1'b1;
        tok_next.row  = row_cnt;
        tok_next.last = last_row;
        row_cnt_next  = row_cnt + ROW_W'(1);
        if (last_row) begin
          state_next = (tok.op == OP_QUERY) ? S_WAIT : S_IDLE;
        end
      end
      S_WAIT: begin
        if (result_taken) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      row_cnt       <= '0;
      sweep_pointer <= '0;
      tok           <= '0;
    end else begin
      state         <= state_next;
      row_cnt       <= row_cnt_next;
      sweep_pointer <= sweep_pointer_next;
      tok           <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_clock    <= '1;
      sweep_amount <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_CLOCK:    max_clock    <= cfg_data[CLK_W-1:0];
        REG_SWEEP_AMOUNT: sweep_amount <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/clock_bitmap_window_counter.sv
// top level: sequencer, chain of 16 counter cells and zero count result register
// insert: the next transaction can follow in the next cycle
// sweep: one row of 16 cells per cycle walked down the cell chain, next accept once the last row is issued
// query: all rows are walked down the cell chain through the s1 and tok_out registers of each cell, the result
// is loaded when the last row leaves the chain, next accept in the cycle after the result is taken
// reset clears all counters in a pass over all rows; in_stall stays high meanwhile
// config writes are taken at any time, including during the clearing pass
module clock_bitmap_window_counter (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [cbwc_pkg::FUNC_W-1:0]    func,
  input  logic [cbwc_pkg::IDX_W-1:0]     cell_index,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [cbwc_pkg::CNT_W-1:0]     zero_count,
  input  logic                           cfg_we,
  input  logic [cbwc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cbwc_pkg::AMT_W-1:0]     cfg_data
);
  import cbwc_pkg::*;

  tok_t             chain [LANES+1];
  tok_t             tail;
  logic [CNT_W-1:0] acc;
  logic [CNT_W-1:0] sum;
  logic             result_taken;

  assign result_taken = out_valid && !out_stall;

  cbwc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .cell_index   (cell_index),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_taken (result_taken),
    .tok          (chain[0])
  );

  for (genvar g = 0; g < LANES; g++) begin : g_cell
    cbwc_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .lane    (LANE_W'(g)),
      .tok_in  (chain[g]),
      .tok_out (chain[g+1])
    );
  end

  assign tail = chain[LANES];
  assign sum  = acc + CNT_W'(tail.zsum);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (result_taken) begin
        out_valid <= 1'b0;
      end
      if (tail.vld && tail.op == OP_QUERY) begin
        if (tail.last) begin
          acc        <= '0;
          zero_count <= sum;
          out_valid  <= 1'b1;
        end else begin
          acc <= sum;
        end
      end
    end
  end

endmodule
